// ----- rtl/core/srfh_pkg.sv -----
// ----------------------------------------------------------------------------
// srfh_pkg
// Types and constants shared by the sphere first-hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package srfh_pkg;

  typedef enum logic {
    FN_APPEND = 1'b0,
    FN_QUERY  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_HIT   = 3'd2,
    ST_HIT      = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        sphere_radius;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        r;
  } obst_t;

  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;
  localparam int RadW  = 64;
  localparam int RootW = RadW / 2;
  localparam int QuoW  = 29;

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_VNORM, S_VSQ_ISS, S_VSQ_ACC, S_SQN_GO, S_SQN_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_SPH_RD, S_SPH_LD, S_DOT_ISS, S_DOT_ACC, S_PL_SET,
    S_UPL_ISS, S_UPL_ACC, S_WABS, S_WSQ_ISS, S_WSQ_ACC, S_RSQ_ISS, S_RSQ_ACC,
    S_TEST, S_DSQ_ISS, S_DSQ_ACC, S_CMP, S_SCAN_END, S_SQR_GO, S_SQR_WAIT,
    S_STEP, S_FIN_ISS, S_FIN_ACC, S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/srfh_mul.sv -----
// ----------------------------------------------------------------------------
// srfh_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module srfh_mul
  import srfh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [MulAW-1:0] a,
  input  wire logic [MulBW-1:0] b,
  output logic      [MulPW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MulPW'(a) * MulPW'(b);
  end

endmodule

`default_nettype wire

// ----- rtl/core/srfh_sqrt.sv -----
// ----------------------------------------------------------------------------
// srfh_sqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srfh_sqrt
  import srfh_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [RadW-1:0] radicand,
  output logic                 done,
  output logic [RootW-1:0]     root
);

  localparam int RemW = RootW + 4;
  localparam int CntW = $clog2(RootW + 1);

  logic [RadW-1:0] rad;
  logic [RemW-1:0] rem;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            take;

  always_comb begin
    rem_sh = {rem[RemW-3:0], rad[RadW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == CntW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CntW'(RootW);
    end else if (run) begin
      rad  <= rad << 2;
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[RootW-2:0], take};
      cnt  <= cnt - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srfh_div.sv -----
// ----------------------------------------------------------------------------
// srfh_div
// Restoring divider: floor(num * 2^28 / den), one quotient bit per cycle.
// Needs num <= den, so the quotient fits in 29 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module srfh_div
  import srfh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [31:0]       num,
  input  wire logic [31:0]       den,
  output logic                   done,
  output logic [QuoW-1:0]        quo
);

  localparam int CntW = $clog2(QuoW + 1);

  logic [31:0]     rem;
  logic [QuoW-1:0] bits;
  logic [31:0]     dvs;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [32:0]     rem_sh;
  logic            take;

  always_comb begin
    rem_sh = {rem, bits[QuoW-1]};
    take   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == CntW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      // num * 2^28: the top 31 bits seed the remainder, num[0] leads the stream
      rem  <= {1'b0, num[31:1]};
      bits <= {num[0], {(QuoW-1){1'b0}}};
      dvs  <= den;
      quo  <= '0;
      cnt  <= CntW'(QuoW);
    end else if (run) begin
      rem  <= take ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      bits <= bits << 1;
      quo  <= {quo[QuoW-2:0], take};
      cnt  <= cnt - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sphere_ray_first_hit.sv -----
// ----------------------------------------------------------------------------
// sphere_ray_first_hit
// Obstacle sphere table with nearest first-hit query for a moving projectile.
// ----------------------------------------------------------------------------
//  channel  | signals            | handshake
//  ---------+--------------------+-------------------------------------------
//  command  | cmd (cmd_t)        | taken when start && !busy
//  result   | result (result_t)  | one-cycle strobe on done, no backpressure
//
//  Append: the write state, then the done cycle. Query: setup (prescale,
//  norm square root, three 29-bit divides), then a test of each stored
//  sphere plus a distance sum for each candidate, a state to end the
//  scan, then on a hit the contact point, ending in the done cycle.
//  All products go through one shared 34x32 multiplier, registered.
//  busy stays high from accept through the done cycle. Reset clears the
//  sphere count; table contents are never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_ray_first_hit
  import srfh_pkg::*;
#(
  parameter int MAX_OBSTACLES = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      k;
  logic [1:0]         j;
  obst_t              mem [MAX_OBSTACLES];
  obst_t              rd;
  logic               mem_we;

  logic signed [31:0] p   [3];
  logic [30:0]        rp;
  logic [31:0]        vm  [3];
  logic               vs  [3];
  logic [63:0]        s2;
  logic [31:0]        n;
  logic [QuoW-1:0]    um  [3];
  logic signed [32:0] dsig [3];
  logic [31:0]        dm  [3];
  logic [31:0]        rsum;
  logic signed [63:0] dot;
  logic [33:0]        pl;
  logic signed [35:0] w   [3];
  logic [31:0]        wm  [3];
  logic               wsat;
  logic [64:0]        dd;
  logic [63:0]        r2;
  logic [65:0]        dsq;
  logic               found;
  logic [65:0]        best_dsq;
  logic [33:0]        best_pl;
  logic [63:0]        best_rad;
  logic signed [34:0] stp;
  logic [33:0]        stepm;
  logic               steps;
  logic signed [31:0] pt  [3];
  status_t            st;

  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [MulPW-1:0]   mul_p;
  logic               sq_go;
  logic [RadW-1:0]    sq_rad;
  logic               sq_done;
  logic [RootW-1:0]   sq_root;
  logic               dv_go;
  logic               dv_done;
  logic [QuoW-1:0]    dv_quo;

  // datapath helpers
  logic [31:0]        vmax;
  logic signed [31:0] cpos [3];
  logic signed [32:0] dnew [3];
  logic signed [32:0] dneg [3];
  logic signed [63:0] prod_s;
  logic [63:0]        dot_abs;
  logic signed [35:0] upl_s;
  logic signed [35:0] w_new;
  logic [35:0]        w_abs [3];
  logic [64:0]        dd_sum;
  logic [65:0]        dsq_sum;
  logic               test_pass;
  logic signed [34:0] stp_new;
  logic signed [35:0] fin_s;
  logic signed [35:0] fin_sum;
  logic signed [31:0] fin_sat;
  logic               full;

  srfh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  srfh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  srfh_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (dv_go),
    .num  (vm[j]),
    .den  (n),
    .done (dv_done),
    .quo  (dv_quo)
  );

  // obstacle table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= '{x: p[0], y: p[1], z: p[2], r: rp};
    end
    rd <= mem[k[AW-1:0]];
  end

  always_comb begin
    full = (count == CW'(MAX_OBSTACLES));
    vmax = vm[0];
    if (vm[1] > vmax) vmax = vm[1];
    if (vm[2] > vmax) vmax = vm[2];
    cpos[0] = rd.x;
    cpos[1] = rd.y;
    cpos[2] = rd.z;
    for (int i = 0; i < 3; i++) begin
      dnew[i]  = 33'(p[i]) - 33'(cpos[i]);
      dneg[i]  = -dnew[i];
      w_abs[i] = w[i][35] ? 36'(-w[i]) : 36'(w[i]);
    end
    prod_s    = $signed(mul_p[63:0]);
    dot_abs   = dot[63] ? 64'(-dot) : 64'(dot);
    upl_s     = $signed({2'b00, mul_p[61:28]});
    w_new     = 36'(dsig[j]) + (vs[j] ? -upl_s : upl_s);
    dd_sum    = {1'b0, dd[63:0]} + {1'b0, mul_p[63:0]};
    dsq_sum   = dsq + {2'b00, mul_p[63:0]};
    test_pass = !wsat && !dd[64] && (dd[63:0] < r2);
    stp_new   = $signed({1'b0, best_pl}) - $signed({3'b000, sq_root});
    fin_s     = $signed({2'b00, mul_p[61:28]});
    fin_sum   = 36'(p[j]) + ((steps ^ vs[j]) ? -fin_s : fin_s);
    if (fin_sum[35:31] == 5'b00000 || fin_sum[35:31] == 5'b11111) begin
      fin_sat = fin_sum[31:0];
    end else if (fin_sum[35]) begin
      fin_sat = 32'sh8000_0000;
    end else begin
      fin_sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        count <= count + CW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (cmd.func == FN_APPEND) ? S_APPEND : S_VNORM;
        end
      end
      S_APPEND:   state_next = S_DONE;
      S_VNORM: begin
        if (vmax == '0) begin
          state_next = S_DONE;
        end else if (vmax[31:30] != 2'b00) begin
          state_next = S_VSQ_ISS;
        end
      end
      S_VSQ_ISS:  state_next = S_VSQ_ACC;
      S_VSQ_ACC:  state_next = (j == 2'd2) ? S_SQN_GO : S_VSQ_ISS;
      S_SQN_GO:   state_next = S_SQN_WAIT;
      S_SQN_WAIT: if (sq_done) state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (dv_done) begin
          state_next = (j == 2'd2) ? S_SPH_RD : S_DIV_GO;
        end
      end
      S_SPH_RD:   state_next = (k < count) ? S_SPH_LD : S_SCAN_END;
      S_SPH_LD:   state_next = S_DOT_ISS;
      S_DOT_ISS:  state_next = S_DOT_ACC;
      S_DOT_ACC:  state_next = (j == 2'd2) ? S_PL_SET : S_DOT_ISS;
      S_PL_SET:   state_next = S_UPL_ISS;
      S_UPL_ISS:  state_next = S_UPL_ACC;
      S_UPL_ACC:  state_next = (j == 2'd2) ? S_WABS : S_UPL_ISS;
      S_WABS:     state_next = S_WSQ_ISS;
      S_WSQ_ISS:  state_next = S_WSQ_ACC;
      S_WSQ_ACC:  state_next = (j == 2'd2) ? S_RSQ_ISS : S_WSQ_ISS;
      S_RSQ_ISS:  state_next = S_RSQ_ACC;
      S_RSQ_ACC:  state_next = S_TEST;
      S_TEST:     state_next = test_pass ? S_DSQ_ISS : S_SPH_RD;
      S_DSQ_ISS:  state_next = S_DSQ_ACC;
      S_DSQ_ACC:  state_next = (j == 2'd2) ? S_CMP : S_DSQ_ISS;
      S_CMP:      state_next = S_SPH_RD;
      S_SCAN_END: state_next = (!found || best_pl == '0) ? S_DONE : S_SQR_GO;
      S_SQR_GO:   state_next = S_SQR_WAIT;
      S_SQR_WAIT: if (sq_done) state_next = S_STEP;
      S_STEP:     state_next = S_FIN_ISS;
      S_FIN_ISS:  state_next = S_FIN_ACC;
      S_FIN_ACC:  state_next = (j == 2'd2) ? S_DONE : S_FIN_ISS;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy   = (state != S_IDLE);
    done   = (state == S_DONE);
    mem_we = (state == S_APPEND) && !full;
    sq_go  = (state == S_SQN_GO) || (state == S_SQR_GO);
    sq_rad = (state == S_SQN_GO) ? s2 : best_rad;
    dv_go  = (state == S_DIV_GO);
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_VSQ_ISS: begin
        mul_a = MulAW'(vm[j]);
        mul_b = vm[j];
      end
      S_DOT_ISS: begin
        mul_a = MulAW'(dm[j]);
        mul_b = MulBW'(um[j]);
      end
      S_UPL_ISS: begin
        mul_a = pl;
        mul_b = MulBW'(um[j]);
      end
      S_WSQ_ISS: begin
        mul_a = MulAW'(wm[j]);
        mul_b = wm[j];
      end
      S_RSQ_ISS: begin
        mul_a = MulAW'(rsum);
        mul_b = rsum;
      end
      S_DSQ_ISS: begin
        mul_a = MulAW'(dm[j]);
        mul_b = dm[j];
      end
      S_FIN_ISS: begin
        mul_a = stepm;
        mul_b = MulBW'(um[j]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          p[0]  <= cmd.pos_x;
          p[1]  <= cmd.pos_y;
          p[2]  <= cmd.pos_z;
          rp    <= cmd.sphere_radius;
          vm[0] <= cmd.vel_x[31] ? 32'(-33'(cmd.vel_x)) : cmd.vel_x;
          vm[1] <= cmd.vel_y[31] ? 32'(-33'(cmd.vel_y)) : cmd.vel_y;
          vm[2] <= cmd.vel_z[31] ? 32'(-33'(cmd.vel_z)) : cmd.vel_z;
          vs[0] <= cmd.vel_x[31];
          vs[1] <= cmd.vel_y[31];
          vs[2] <= cmd.vel_z[31];
          for (int i = 0; i < 3; i++) begin
            pt[i] <= '0;
          end
          s2 <= '0;
          j  <= '0;
        end
      end
      S_APPEND: st <= full ? ST_FULL : ST_APPENDED;
      S_VNORM: begin
        if (vmax == '0) begin
          st <= ST_INVALID;
        end else if (vmax[31:30] == 2'b00) begin
          for (int i = 0; i < 3; i++) begin
            vm[i] <= vm[i] << 1;
          end
        end
      end
      S_VSQ_ACC: begin
        s2 <= s2 + mul_p[63:0];
        j  <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_SQN_WAIT: if (sq_done) n <= sq_root;
      S_DIV_WAIT: begin
        if (dv_done) begin
          um[j] <= dv_quo;
          j     <= (j == 2'd2) ? 2'd0 : j + 2'd1;
          k     <= '0;
          found <= 1'b0;
        end
      end
      S_SPH_LD: begin
        for (int i = 0; i < 3; i++) begin
          dsig[i] <= dnew[i];
          dm[i]   <= dnew[i][32] ? dneg[i][31:0] : dnew[i][31:0];
        end
        rsum <= 32'(rp) + 32'(rd.r);
        dot  <= '0;
      end
      S_DOT_ACC: begin
        dot <= dot + ((dsig[j][32] ^ vs[j]) ? -prod_s : prod_s);
        j   <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_PL_SET: pl <= dot_abs[61:28];
      S_UPL_ACC: begin
        w[j] <= w_new;
        j    <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_WABS: begin
        for (int i = 0; i < 3; i++) begin
          wm[i] <= w_abs[i][31:0];
        end
        wsat <= (w_abs[0][35:32] != '0) || (w_abs[1][35:32] != '0) ||
                (w_abs[2][35:32] != '0);
        dd   <= '0;
      end
      S_WSQ_ACC: begin
        dd <= {dd[64] | dd_sum[64], dd_sum[63:0]};
        j  <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_RSQ_ACC: r2 <= mul_p[63:0];
      S_TEST: begin
        dsq <= '0;
        if (!test_pass) k <= k + CW'(1);
      end
      S_DSQ_ACC: begin
        dsq <= dsq_sum;
        j   <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_CMP: begin
        // strict compare: on a tie the earlier sphere stays
        if (!found || dsq < best_dsq) begin
          found    <= 1'b1;
          best_dsq <= dsq;
          best_pl  <= pl;
          best_rad <= r2 - dd[63:0];
        end
        k <= k + CW'(1);
      end
      S_SCAN_END: begin
        if (!found) begin
          st <= ST_NO_HIT;
        end else if (best_pl == '0) begin
          st <= ST_INVALID;
        end
      end
      S_SQR_WAIT: if (sq_done) stp <= stp_new;
      S_STEP: begin
        stepm <= stp[34] ? 34'(-stp) : 34'(stp);
        steps <= stp[34];
      end
      S_FIN_ACC: begin
        pt[j] <= fin_sat;
        j     <= (j == 2'd2) ? 2'd0 : j + 2'd1;
        if (j == 2'd2) st <= ST_HIT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.status  = st;
    result.point_x = pt[0];
    result.point_y = pt[1];
    result.point_z = pt[2];
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_HIT) |->
      (result.point_x == '0 && result.point_y == '0 && result.point_z == '0))
    else $error("nonzero point on a non-hit result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_OBSTACLES))
    else $error("sphere count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not start work");

  a_lane_idx: assert property (@(posedge clk) disable iff (rst)
    busy |-> (j != 2'd3))
    else $error("component index out of range");

endmodule

`default_nettype wire
